@@ hw/rtl/rbefs_pkg.sv @@
package rbefs_pkg;

   // Field widths
   localparam int unsigned FixW   = 32;
   localparam int unsigned DtW    = 17;
   localparam int unsigned CfgW   = 31;
   localparam int unsigned FmW    = 46;
   localparam int unsigned FricW  = 47;
   localparam int unsigned OpW    = 5;

   // Iteration counts of the shared divider and the square root unit
   localparam int unsigned DivSteps  = 64;
   localparam int unsigned SqrtSteps = 32;
   localparam int unsigned CntW      = $clog2(DivSteps);

   // Configuration register indexes
   localparam logic CsrBodyMass = 1'b0;
   localparam logic CsrFriction = 1'b1;

   // Reset values of the configuration registers
   localparam logic [CfgW-1:0] MassReset = 31'd65536;
   localparam logic [CfgW-1:0] FricReset = 31'd6553600;

   // Datapath operation codes
   localparam logic [OpW-1:0] OpNop       = 5'd0;
   localparam logic [OpW-1:0] OpLoad      = 5'd1;
   localparam logic [OpW-1:0] OpDivAInit  = 5'd2;
   localparam logic [OpW-1:0] OpDivStep   = 5'd3;
   localparam logic [OpW-1:0] OpAccStore  = 5'd4;
   localparam logic [OpW-1:0] OpMulAdt    = 5'd5;
   localparam logic [OpW-1:0] OpVelAdd    = 5'd6;
   localparam logic [OpW-1:0] OpMulFm     = 5'd7;
   localparam logic [OpW-1:0] OpFmStore   = 5'd8;
   localparam logic [OpW-1:0] OpMulFlo    = 5'd9;
   localparam logic [OpW-1:0] OpFLo       = 5'd10;
   localparam logic [OpW-1:0] OpMulFhi    = 5'd11;
   localparam logic [OpW-1:0] OpFHi       = 5'd12;
   localparam logic [OpW-1:0] OpMulSqx    = 5'd13;
   localparam logic [OpW-1:0] OpSqLo      = 5'd14;
   localparam logic [OpW-1:0] OpMulSqy    = 5'd15;
   localparam logic [OpW-1:0] OpSqAdd     = 5'd16;
   localparam logic [OpW-1:0] OpSqrtInit  = 5'd17;
   localparam logic [OpW-1:0] OpSqrtStep  = 5'd18;
   localparam logic [OpW-1:0] OpVelZero   = 5'd19;
   localparam logic [OpW-1:0] OpMulVf     = 5'd20;
   localparam logic [OpW-1:0] OpDivFInit  = 5'd21;
   localparam logic [OpW-1:0] OpFricStore = 5'd22;
   localparam logic [OpW-1:0] OpMulPdt    = 5'd23;
   localparam logic [OpW-1:0] OpPosStore  = 5'd24;
   localparam logic [OpW-1:0] OpOutLoad   = 5'd25;

   // Command from the controller: operation and component select (0 is x, 1 is y)
   typedef struct packed {
      logic [OpW-1:0] op;
      logic           sel;
   } cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic v_zero;
      logic s_lt_f;
   } sts_type;

   // Magnitude of a signed word; the most negative value maps to 2^31
   function automatic logic [FixW-1:0] abs32(input logic signed [FixW-1:0] v);
      logic [FixW-1:0] r;
      r = v[FixW-1] ? (~v + 32'd1) : v;
      return r;
   endfunction

   // Saturation of a wide signed value to the signed 32-bit range
   function automatic logic signed [FixW-1:0] sat32(input logic signed [65:0] v);
      logic signed [FixW-1:0] r;
      if (v > 66'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[FixW-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/rbefs_ctrl.sv @@
module rbefs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  rbefs_pkg::sts_type sts,
   output rbefs_pkg::cmd_type cmd
);
   import rbefs_pkg::*;

   localparam logic [4:0] SIdle      = 5'd0;
   localparam logic [4:0] SDaInit    = 5'd1;
   localparam logic [4:0] SDaStep    = 5'd2;
   localparam logic [4:0] SAccStore  = 5'd3;
   localparam logic [4:0] SMulAdt    = 5'd4;
   localparam logic [4:0] SVelAdd    = 5'd5;
   localparam logic [4:0] SCheck     = 5'd6;
   localparam logic [4:0] SMulFm     = 5'd7;
   localparam logic [4:0] SFmStore   = 5'd8;
   localparam logic [4:0] SMulFlo    = 5'd9;
   localparam logic [4:0] SFLo       = 5'd10;
   localparam logic [4:0] SMulFhi    = 5'd11;
   localparam logic [4:0] SFHi       = 5'd12;
   localparam logic [4:0] SMulSqx    = 5'd13;
   localparam logic [4:0] SSqLo      = 5'd14;
   localparam logic [4:0] SMulSqy    = 5'd15;
   localparam logic [4:0] SSqAdd     = 5'd16;
   localparam logic [4:0] SSqrtInit  = 5'd17;
   localparam logic [4:0] SSqrtStep  = 5'd18;
   localparam logic [4:0] SCompare   = 5'd19;
   localparam logic [4:0] SVelZero   = 5'd20;
   localparam logic [4:0] SMulVf     = 5'd21;
   localparam logic [4:0] SDfInit    = 5'd22;
   localparam logic [4:0] SDfStep    = 5'd23;
   localparam logic [4:0] SFricStore = 5'd24;
   localparam logic [4:0] SMulPdt    = 5'd25;
   localparam logic [4:0] SPosStore  = 5'd26;
   localparam logic [4:0] SOut       = 5'd27;

   localparam logic [CntW-1:0] DivLast  = CntW'(DivSteps - 1);
   localparam logic [CntW-1:0] SqrtLast = CntW'(SqrtSteps - 1);

   logic [4:0]      state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            sel_ff, sel_in;
   logic            valid_ff, valid_in;
   logic            out_free;

   assign req_tready = (state_ff == SIdle);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   // Sequencing of the datapath operations
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      cmd.op   = OpNop;
      cmd.sel  = sel_ff;
      case (state_ff)
         SIdle: begin
            if (req_tvalid) begin
               cmd.op   = OpLoad;
               sel_in   = 1'b0;
               state_in = SDaInit;
            end
         end
         SDaInit: begin
            cmd.op   = OpDivAInit;
            cnt_in   = '0;
            state_in = SDaStep;
         end
         SDaStep: begin
            cmd.op = OpDivStep;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivLast) begin
               state_in = SAccStore;
            end
         end
         SAccStore: begin
            cmd.op   = OpAccStore;
            state_in = SMulAdt;
         end
         SMulAdt: begin
            cmd.op   = OpMulAdt;
            state_in = SVelAdd;
         end
         SVelAdd: begin
            cmd.op = OpVelAdd;
            sel_in = !sel_ff;
            state_in = sel_ff ? SCheck : SDaInit;
         end
         SCheck: begin
            state_in = sts.v_zero ? SMulPdt : SMulFm;
         end
         SMulFm: begin
            cmd.op   = OpMulFm;
            state_in = SFmStore;
         end
         SFmStore: begin
            cmd.op   = OpFmStore;
            state_in = SMulFlo;
         end
         SMulFlo: begin
            cmd.op   = OpMulFlo;
            state_in = SFLo;
         end
         SFLo: begin
            cmd.op   = OpFLo;
            state_in = SMulFhi;
         end
         SMulFhi: begin
            cmd.op   = OpMulFhi;
            state_in = SFHi;
         end
         SFHi: begin
            cmd.op   = OpFHi;
            state_in = SMulSqx;
         end
         SMulSqx: begin
            cmd.op   = OpMulSqx;
            state_in = SSqLo;
         end
         SSqLo: begin
            cmd.op   = OpSqLo;
            state_in = SMulSqy;
         end
         SMulSqy: begin
            cmd.op   = OpMulSqy;
            state_in = SSqAdd;
         end
         SSqAdd: begin
            cmd.op   = OpSqAdd;
            state_in = SSqrtInit;
         end
         SSqrtInit: begin
            cmd.op   = OpSqrtInit;
            cnt_in   = '0;
            state_in = SSqrtStep;
         end
         SSqrtStep: begin
            cmd.op = OpSqrtStep;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SqrtLast) begin
               state_in = SCompare;
            end
         end
         SCompare: begin
            sel_in   = 1'b0;
            state_in = sts.s_lt_f ? SVelZero : SMulVf;
         end
         SVelZero: begin
            cmd.op   = OpVelZero;
            state_in = SMulPdt;
         end
         SMulVf: begin
            cmd.op   = OpMulVf;
            state_in = SDfInit;
         end
         SDfInit: begin
            cmd.op   = OpDivFInit;
            cnt_in   = '0;
            state_in = SDfStep;
         end
         SDfStep: begin
            cmd.op = OpDivStep;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivLast) begin
               state_in = SFricStore;
            end
         end
         SFricStore: begin
            cmd.op   = OpFricStore;
            sel_in   = !sel_ff;
            state_in = sel_ff ? SMulPdt : SMulVf;
         end
         SMulPdt: begin
            cmd.op   = OpMulPdt;
            state_in = SPosStore;
         end
         SPosStore: begin
            cmd.op   = OpPosStore;
            sel_in   = !sel_ff;
            state_in = sel_ff ? SOut : SMulPdt;
         end
         SOut: begin
            if (out_free) begin
               cmd.op   = OpOutLoad;
               state_in = SIdle;
            end
         end
         default: begin
            state_in = SIdle;
         end
      endcase
   end

   // Result valid: set when the output register is loaded, cleared on transfer
   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.op == OpOutLoad) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
         cnt_ff   <= '0;
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ hw/rtl/rbefs_dp.sv @@
module rbefs_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  rbefs_pkg::cmd_type        cmd,
   output rbefs_pkg::sts_type        sts,
   input  logic                      csr_wen,
   input  logic                      csr_index,
   input  logic [30:0]               csr_wdata,
   input  logic [151:0]              req_tdata,
   output logic [127:0]              rsp_tdata
);
   import rbefs_pkg::*;

   // Configuration
   logic [CfgW-1:0] mass_ff, fric_ff, meff_ff, meff_in;

   // Latched item
   logic signed [FixW-1:0] fx_ff, fy_ff, px_ff, py_ff;
   logic [DtW-1:0]         dt_ff;

   // Working values
   logic signed [FixW-1:0] ax_ff, ay_ff, vx_ff, vy_ff, qx_ff, qy_ff;
   logic [63:0]            prod_ff, prod_in;
   logic [FmW-1:0]         fm_ff;
   logic [48:0]            facc_ff;
   logic [FricW-1:0]       f_ff;
   logic [63:0]            sq_ff, res_ff, bit_ff;
   logic [63:0]            dvd_ff;
   logic [FixW-1:0]        rem_ff, dvs_ff;
   logic                   neg_ff;
   logic [127:0]           out_ff;

   // Per-component selections
   logic signed [FixW-1:0] f_sel, a_sel, v_sel, p_sel;
   logic [FixW-1:0]        v_mag;
   logic [31:0]            mul_a, mul_b;
   logic                   mul_en;
   logic [32:0]            div_t;
   logic                   div_ge;
   logic [63:0]            sq_trial, f_sum;
   logic signed [65:0]     acc_wide, vel_wide, fric_wide, pos_wide;
   logic signed [FixW-1:0] acc_new, vel_new, fric_new, pos_new;
   logic [32:0]            fric_diff;

   assign f_sel = cmd.sel ? fy_ff : fx_ff;
   assign a_sel = cmd.sel ? ay_ff : ax_ff;
   assign v_sel = cmd.sel ? vy_ff : vx_ff;
   assign p_sel = cmd.sel ? py_ff : px_ff;
   assign v_mag = abs32(v_sel);
   assign meff_in = (mass_ff == '0) ? 31'd1 : mass_ff;

   assign sts.v_zero = (vx_ff == '0) && (vy_ff == '0);
   assign sts.s_lt_f = res_ff < {17'd0, f_ff};
   assign rsp_tdata  = out_ff;

   // Shared multiplier operand selection
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (cmd.op)
         OpMulAdt: begin
            mul_a = abs32(a_sel);
            mul_b = {15'd0, dt_ff};
         end
         OpMulFm: begin
            mul_a = {1'b0, fric_ff};
            mul_b = {1'b0, meff_ff};
         end
         OpMulFlo: begin
            mul_a = fm_ff[31:0];
            mul_b = {15'd0, dt_ff};
         end
         OpMulFhi: begin
            mul_a = {18'd0, fm_ff[FmW-1:32]};
            mul_b = {15'd0, dt_ff};
         end
         OpMulSqx: begin
            mul_a = abs32(vx_ff);
            mul_b = abs32(vx_ff);
         end
         OpMulSqy: begin
            mul_a = abs32(vy_ff);
            mul_b = abs32(vy_ff);
         end
         OpMulVf: begin
            mul_a = v_mag;
            mul_b = f_ff[31:0];
         end
         OpMulPdt: begin
            mul_a = v_mag;
            mul_b = {15'd0, dt_ff};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // One restoring division step and one square root step
   assign div_t    = {rem_ff, dvd_ff[63]};
   assign div_ge   = div_t >= {1'b0, dvs_ff};
   assign sq_trial = res_ff + bit_ff;

   // Friction constant: upper partial product joined to the lower one
   assign f_sum = {15'd0, facc_ff} + {prod_ff[31:0], 32'd0};

   // Signed results, each saturated to 32 bits
   always_comb begin
      acc_wide  = neg_ff ? -$signed({2'b00, dvd_ff}) : $signed({2'b00, dvd_ff});
      acc_new   = sat32(acc_wide);
      vel_wide  = a_sel[FixW-1] ? (66'(v_sel) - $signed({18'd0, prod_ff[63:16]}))
                                : (66'(v_sel) + $signed({18'd0, prod_ff[63:16]}));
      vel_new   = sat32(vel_wide);
      fric_diff = {1'b0, v_mag} - {1'b0, dvd_ff[31:0]};
      fric_wide = v_sel[FixW-1] ? -$signed({33'd0, fric_diff}) : $signed({33'd0, fric_diff});
      fric_new  = sat32(fric_wide);
      pos_wide  = v_sel[FixW-1] ? (66'(p_sel) - $signed({18'd0, prod_ff[63:16]}))
                                : (66'(p_sel) + $signed({18'd0, prod_ff[63:16]}));
      pos_new   = sat32(pos_wide);
   end

   // Configuration registers and velocity state
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= MassReset;
         fric_ff <= FricReset;
         vx_ff   <= '0;
         vy_ff   <= '0;
      end else begin
         if (csr_wen && csr_index == CsrBodyMass) begin
            mass_ff <= csr_wdata;
         end
         if (csr_wen && csr_index == CsrFriction) begin
            fric_ff <= csr_wdata;
         end
         case (cmd.op)
            OpVelAdd: begin
               if (cmd.sel) vy_ff <= vel_new;
               else         vx_ff <= vel_new;
            end
            OpFricStore: begin
               if (cmd.sel) vy_ff <= fric_new;
               else         vx_ff <= fric_new;
            end
            OpVelZero: begin
               vx_ff <= '0;
               vy_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Working registers of the datapath
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      case (cmd.op)
         OpLoad: begin
            fx_ff   <= req_tdata[31:0];
            fy_ff   <= req_tdata[63:32];
            dt_ff   <= req_tdata[80:64];
            px_ff   <= req_tdata[112:81];
            py_ff   <= req_tdata[144:113];
            meff_ff <= meff_in;
         end
         OpDivAInit: begin
            dvd_ff <= {16'd0, abs32(f_sel), 16'd0};
            dvs_ff <= {1'b0, meff_ff};
            rem_ff <= '0;
            neg_ff <= f_sel[FixW-1];
         end
         OpDivFInit: begin
            dvd_ff <= prod_ff;
            dvs_ff <= res_ff[31:0];
            rem_ff <= '0;
         end
         OpDivStep: begin
            rem_ff <= div_ge ? 32'(div_t - {1'b0, dvs_ff}) : div_t[31:0];
            dvd_ff <= {dvd_ff[62:0], div_ge};
         end
         OpAccStore: begin
            if (cmd.sel) ay_ff <= acc_new;
            else         ax_ff <= acc_new;
         end
         OpFmStore: begin
            fm_ff <= prod_ff[61:16];
         end
         OpFLo: begin
            facc_ff <= prod_ff[48:0];
         end
         OpFHi: begin
            f_ff <= f_sum[62:16];
         end
         OpSqLo: begin
            sq_ff <= prod_ff;
         end
         OpSqAdd: begin
            sq_ff <= sq_ff + prod_ff;
         end
         OpSqrtInit: begin
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         OpSqrtStep: begin
            if (sq_ff >= sq_trial) begin
               sq_ff  <= sq_ff - sq_trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OpPosStore: begin
            if (cmd.sel) qy_ff <= pos_new;
            else         qx_ff <= pos_new;
         end
         OpOutLoad: begin
            out_ff <= {qy_ff, qx_ff, vy_ff, vx_ff};
         end
         default: begin
         end
      endcase
   end

endmodule

@@ hw/rtl/rigid_body_euler_friction_step.sv @@
// Work per item depends on the path: velocity zero after the force update, friction
// stopping the body, or friction applied. One item at a time; a new item is taken once
// the result is in the output register. The run time is set by the shared
// one-bit-per-cycle divider (two 64-step divisions for the acceleration, two more when
// friction is applied) and the 32-step square root. Synchronous active-high reset
// clears the velocity and the controller and restores the register defaults.
module rigid_body_euler_friction_step (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // force_x, force_y, time_step, pos_in_x, pos_in_y, zero fill
   input  logic [151:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // vel_out_x, vel_out_y, pos_out_x, pos_out_y
   output logic [127:0]  rsp_tdata,
   input  logic          csr_wen,
   input  logic          csr_index,
   input  logic [30:0]   csr_wdata
);
   import rbefs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   rbefs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Arithmetic and state
   rbefs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   // An accepted item keeps the input side closed on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while an item is in progress");

   // Loading the output register always raises the result valid.
   a_valid_after_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OpOutLoad) |=> rsp_tvalid)
      else $error("result loaded without valid");

   // The output register is never loaded over a waiting result.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OpOutLoad) |-> (!rsp_tvalid || rsp_tready))
      else $error("waiting result overwritten");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

// Scoreboard for the Euler step: holds the predicted body state and the queue of
// expected step results, and compares each result transfer against the oldest one.
class euler_scoreboard;
   logic [30:0]        mass_q;
   logic [30:0]        fric_q;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic [127:0]       pending_steps[$];
   int                 mismatches;
   int                 results_seen;
   int                 friction_stops;

   function new();
      mass_q = rbefs_pkg::MassReset;
      fric_q = rbefs_pkg::FricReset;
      vel_x = 0;
      vel_y = 0;
      mismatches = 0;
      results_seen = 0;
      friction_stops = 0;
   endfunction

   function void write_reg(logic idx, logic [30:0] val);
      if (idx == rbefs_pkg::CsrBodyMass) begin
         mass_q = val;
      end else begin
         fric_q = val;
      end
   endfunction

   // Clamp a wide signed value to the 32-bit range.
   function logic signed [31:0] clamp(logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -128'sh8000_0000) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Integer square root, rounded down.
   function logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Reduce one component by v * f / s, truncating the magnitude.
   function logic signed [31:0] slow_down(logic signed [31:0] v, logic [63:0] f,
                                          logic [63:0] s);
      logic [127:0]        mag;
      logic [127:0]        d;
      logic signed [127:0] r;
      mag = (v < 0) ? -{{96{v[31]}}, v} : {96'd0, v};
      d = (mag * f) / s;
      r = (v < 0) ? $signed(d) - $signed(mag) : $signed(mag) - $signed(d);
      return clamp(r);
   endfunction

   // Signed wide division truncating toward zero.
   function logic signed [127:0] div_tz(logic signed [127:0] n, logic signed [127:0] d);
      logic neg;
      logic [127:0] q;
      neg = (n < 0) != (d < 0);
      q = ((n < 0) ? -n : n) / ((d < 0) ? -d : d);
      return neg ? -$signed(q) : $signed(q);
   endfunction

   // Work out the step result for an accepted input and queue it.
   function void note_step(logic [151:0] data);
      logic signed [127:0] fx, fy, px, py, dt, m, ax, ay;
      logic [63:0]         fm, f, s, sq;
      logic signed [63:0]  wx, wy;
      logic signed [31:0]  nx, ny;
      fx = $signed(data[31:0]);
      fy = $signed(data[63:32]);
      dt = {111'd0, data[80:64]};
      px = $signed(data[112:81]);
      py = $signed(data[144:113]);
      m = (mass_q == 0) ? 128'sd1 : {97'd0, mass_q};
      ax = clamp(div_tz(fx * 65536, m));
      ay = clamp(div_tz(fy * 65536, m));
      vel_x = clamp(vel_x + div_tz(ax * dt, 65536));
      vel_y = clamp(vel_y + div_tz(ay * dt, 65536));
      if (vel_x != 0 || vel_y != 0) begin
         fm = ({33'd0, fric_q} * m[63:0]) / 65536;
         f = (fm * dt[63:0]) / 65536;
         wx = vel_x;
         wy = vel_y;
         sq = wx * wx + wy * wy;
         s = root_floor(sq);
         if (s < f) begin
            vel_x = 0;
            vel_y = 0;
            friction_stops++;
         end else begin
            vel_x = slow_down(vel_x, f, s);
            vel_y = slow_down(vel_y, f, s);
         end
      end
      nx = clamp(px + div_tz(vel_x * dt, 65536));
      ny = clamp(py + div_tz(vel_y * dt, 65536));
      pending_steps.push_back({ny, nx, vel_y, vel_x});
   endfunction

   function void check_result(logic [127:0] got);
      logic [127:0] exp_r;
      results_seen++;
      if (pending_steps.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      exp_r = pending_steps.pop_front();
      for (int k = 0; k < 4; k++) begin
         if (got[32*k +: 32] !== exp_r[32*k +: 32]) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("field %0d: expected %h, got %h", k, exp_r[32*k +: 32],
                        got[32*k +: 32]);
            end
         end
      end
   endfunction
endclass

module tb;
   import rbefs_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic         csr_wen = 0;
   logic         csr_index = 0;
   logic [30:0]  csr_wdata = '0;

   euler_scoreboard board;
   int  quiet_cycles = 0;
   int  steps_sent = 0;
   bit  hold_rsp = 0;

   localparam int QuietLimit = 20000;
   localparam int SettleCycles = 400;
   localparam int HoldCycles = 1500;

   rigid_body_euler_friction_step uut (.*);

   always #6 clock = ~clock;

   // Watchdog: cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("** rigid_body_euler_friction_step: FAILED **");
         $finish;
      end
   end

   // Note each input transfer and check each result transfer.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_step(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   // Receiver: random stall per result, or a long counted hold-off when asked.
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (HoldCycles) @(negedge clock);
            hold_rsp = 0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
               rsp_tready <= 0;
               repeat (gap) @(negedge clock);
            end
            rsp_tready <= 1;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
            @(negedge clock);
         end
      end
   end

   task automatic write_csr(logic idx, logic [30:0] val);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      board.write_reg(idx, val);
      @(negedge clock);
      csr_wen <= 0;
      @(negedge clock);
   endtask

   // Close the input, wait for every expected result, then let the block settle.
   task automatic drain();
      req_tvalid <= 0;
      while (board.pending_steps.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // The valid stays up after a transfer so that a following item can go back to
   // back; a gap or a drain lowers it.
   task automatic send_step(logic signed [31:0] fx, logic signed [31:0] fy,
                            logic [16:0] dt, logic signed [31:0] px,
                            logic signed [31:0] py, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, py, px, dt, fy, fx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      steps_sent++;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 65536 * 4) - 65536 * 2;
         3: return $urandom_range(0, 255) - 128;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] rand_dt();
      case ($urandom_range(0, 5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'h1FFFF;
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [30:0] rand_mass();
      case ($urandom_range(0, 4))
         0: return 31'd1;
         1: return 31'h7FFF_FFFF;
         2: return 31'd0;
         default: return 31'($urandom_range(1 << 12, 1 << 20));
      endcase
   endfunction

   function automatic logic [30:0] rand_fric();
      case ($urandom_range(0, 4))
         0: return 31'd0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(0, 64));
         default: return 31'($urandom_range(0, 1 << 16));
      endcase
   endfunction

   // Main stimulus.
   initial begin
      board = new();
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: defaults, then field extremes with no friction and with the largest settings.
      send_step(32'h0001_0000, 0, 17'd65536, 0, 0, 0);
      send_step(32'h7FFF_FFFF, 32'h8000_0000, 17'd65536, 32'h7FFF_FFFF,
                32'h8000_0000, 0);
      send_step(0, 0, 17'd0, 32'h1234_5678, 32'hFEDC_BA98, 0);
      drain();
      write_csr(CsrFriction, 31'd0);
      write_csr(CsrBodyMass, 31'd0);
      send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 0);
      send_step(32'h8000_0000, 32'h8000_0000, 17'h1FFFF, 32'h8000_0000,
                32'h8000_0000, 0);
      send_step(32'hFFFF_FFFF, 32'h0000_0001, 17'd1, 32'hFFFF_FFFF, 1, 0);
      drain();
      write_csr(CsrBodyMass, 31'h7FFF_FFFF);
      write_csr(CsrFriction, 31'h7FFF_FFFF);
      send_step(32'h7FFF_FFFF, 0, 17'd65536, 0, 0, 0);
      send_step(0, 0, 17'd1, 0, 0, 0);
      drain();
      // Friction that roughly equals the speed of a unit step.
      write_csr(CsrBodyMass, 31'd65536);
      write_csr(CsrFriction, 31'd65536);
      send_step(32'h0001_0000, 0, 17'd65536, 0, 0, 0);
      send_step(32'h0003_0000, 32'h0004_0000, 17'd65536, 0, 0, 0);
      send_step(32'h0002_0000, 32'h0000_0000, 17'd32768, 5, 5, 0);
      drain();

      // Random phases with fresh register settings between them.
      for (int ph = 0; ph < 12; ph++) begin
         write_csr(CsrBodyMass, rand_mass());
         write_csr(CsrFriction, rand_fric());
         if (ph == 3) hold_rsp = 1;
         for (int n = 0; n < 135; n++) begin
            send_step(rand_word(), rand_word(), rand_dt(), rand_word(), rand_word(),
                      ph == 3);
            if (ph == 6 && n == 60) begin
               req_tvalid <= 0;
               while (board.pending_steps.size() != 0) @(negedge clock);
               @(negedge clock);
            end
         end
         drain();
      end

      $display("Ran %0d steps with %0d results over 12 register settings;",
               steps_sent, board.results_seen);
      $display("friction brought the body to rest %0d times.", board.friction_stops);
      if (board.mismatches == 0 && board.pending_steps.size() == 0) begin
         $display("** rigid_body_euler_friction_step: PASSED **");
      end else begin
         $display("** rigid_body_euler_friction_step: FAILED **");
      end
      $finish;
   end
endmodule
